// ===== rtl/core/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file refers to this package by scoped name.
package u16u8_pkg;

   localparam int UnitW    = 16;
   localparam int ByteW    = 8;
   localparam int MaxBytes = 4;
   localparam int CntW     = 2;   // holds byte count minus one
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 1;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   // Register indexes on the configuration port
   localparam logic [CsrIdxW-1:0] CSR_PASS_RAW      = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_LITTLE_ENDIAN = 2'd1;

   // Surrogate ranges, by the top six bits of a code unit
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   localparam logic [20:0] SUPP_BASE = 21'h10000;

   // One classified request, as queued between front and back
   typedef struct packed {
      logic [MaxBytes-1:0][ByteW-1:0] bytes;        // bytes[0] goes out first
      logic [CntW-1:0]                last_idx;     // number of results minus one
      logic                           has_byte;
      logic                           pair_error;
      logic                           status_error;
   } entry_type;

endpackage

// ===== rtl/core/u16u8_front.sv =====
// Front end: accepts code units, holds configuration and surrogate state,
// and turns each request into one queue entry. Depends on u16u8_pkg.
module u16u8_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [u16u8_pkg::UnitW-1:0]      req_code_unit,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u16u8_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [u16u8_pkg::CsrDataW-1:0]   csr_data,
   input  logic                             q_full,
   output logic                             q_push,
   output u16u8_pkg::entry_type             q_entry
);

   logic        keep_ff, keep_in;
   logic        le_ff, le_in;
   logic        pend_ff, pend_in;       // a lead surrogate is waiting
   logic [9:0]  lead_ff, lead_in;       // its low ten bits
   logic        sticky_ff, sticky_in;

   logic        is_high, is_low;
   logic [20:0] cp;
   u16u8_pkg::entry_type ent;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = ent;

   assign is_high = (req_code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
   assign is_low  = (req_code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG);
   assign cp      = u16u8_pkg::SUPP_BASE + {1'b0, lead_ff, req_code_unit[9:0]};

   always_comb begin
      keep_in   = keep_ff;
      le_in     = le_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            u16u8_pkg::CSR_PASS_RAW:      keep_in = csr_data[0];
            u16u8_pkg::CSR_LITTLE_ENDIAN: le_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pend_in          = pend_ff;
      lead_in          = lead_ff;
      sticky_in        = sticky_ff;
      ent.bytes        = '0;
      ent.last_idx     = '0;
      ent.has_byte     = 1'b1;
      ent.pair_error   = 1'b0;
      if (keep_ff) begin
         ent.bytes[0] = le_ff ? req_code_unit[7:0]  : req_code_unit[15:8];
         ent.bytes[1] = le_ff ? req_code_unit[15:8] : req_code_unit[7:0];
         ent.last_idx = 2'd1;
      end else if ((pend_ff && !is_low) || (is_low && !pend_ff)) begin
         // missing low or missing high surrogate; unit dropped, lead kept
         sticky_in      = 1'b1;
         ent.has_byte   = 1'b0;
         ent.pair_error = 1'b1;
      end else if (is_high) begin
         pend_in      = 1'b1;
         lead_in      = req_code_unit[9:0];
         ent.has_byte = 1'b0;
      end else if (is_low) begin
         pend_in      = 1'b0;
         ent.bytes[0] = {5'b11110, cp[20:18]};
         ent.bytes[1] = {2'b10, cp[17:12]};
         ent.bytes[2] = {2'b10, cp[11:6]};
         ent.bytes[3] = {2'b10, cp[5:0]};
         ent.last_idx = 2'd3;
      end else if (req_code_unit[15:7] == 9'd0) begin
         ent.bytes[0] = req_code_unit[7:0];
      end else if (req_code_unit[15:11] == 5'd0) begin
         ent.bytes[0] = {3'b110, req_code_unit[10:6]};
         ent.bytes[1] = {2'b10, req_code_unit[5:0]};
         ent.last_idx = 2'd1;
      end else begin
         ent.bytes[0] = {4'b1110, req_code_unit[15:12]};
         ent.bytes[1] = {2'b10, req_code_unit[11:6]};
         ent.bytes[2] = {2'b10, req_code_unit[5:0]};
         ent.last_idx = 2'd2;
      end
      ent.status_error = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff   <= 1'b0;
         le_ff     <= 1'b1;
         pend_ff   <= 1'b0;
         sticky_ff <= 1'b0;
      end else begin
         keep_ff <= keep_in;
         le_ff   <= le_in;
         if (q_push) begin
            pend_ff   <= pend_in;
            sticky_ff <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         lead_ff <= lead_in;
      end
   end

endmodule

// ===== rtl/core/u16u8_queue.sv =====
// Small entry queue between front and back ends.
// Depends on u16u8_pkg for the entry type and depth.
module u16u8_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u16u8_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output u16u8_pkg::entry_type head
);

   localparam int Aw = u16u8_pkg::QueueAw;

   u16u8_pkg::entry_type slot_ff [u16u8_pkg::QueueDepth];
   logic [Aw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Aw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Aw:0]   count_ff, count_in;

   assign full  = (count_ff == (Aw+1)'(u16u8_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Aw+1)'(push) - (Aw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/u16u8_back.sv =====
// Back end: walks the head entry one byte per cycle, unless stalled, into the result register.
// Depends on u16u8_pkg for the entry type.
module u16u8_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  u16u8_pkg::entry_type            q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [u16u8_pkg::ByteW-1:0]     rsp_out_byte,
   output logic                            rsp_has_byte,
   output logic                            rsp_last,
   output logic                            rsp_pair_error,
   output logic                            rsp_status_error
);

   logic [u16u8_pkg::CntW-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       load;
   logic       at_last;
   logic [u16u8_pkg::ByteW-1:0] byte_ff;
   logic       has_ff, last_ff, perr_ff, serr_ff;

   assign at_last = (idx_ff == q_head.last_idx);
   assign load    = (!valid_ff || !rsp_stall) && !q_empty;
   assign q_pop   = load && at_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = !q_empty;
      end
      if (load) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= q_head.bytes[idx_ff];
         has_ff  <= q_head.has_byte;
         last_ff <= at_last;
         perr_ff <= q_head.pair_error;
         serr_ff <= q_head.status_error;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_has_byte     = has_ff;
   assign rsp_last         = last_ff;
   assign rsp_pair_error   = perr_ff;
   assign rsp_status_error = serr_ff;

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: front end, entry queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Usage:
//  - req_* channel takes one 16-bit code unit per request (valid/stall).
//  - rsp_* channel returns result items one per cycle unless stalled: a UTF-8
//    byte, a raw UTF-16 half in pass-through mode, or a no-byte marker for a
//    stored lead or a pairing fault. rsp_last marks the final item of each request.
//  - csr_* port writes the pass-through enable (index 0) and little_endian
//    (index 1); csr_ready is always high. Write only while the block is idle.
//  - Path: an accepted request is first registered into the queue by the
//    front; the back then registers its first byte from the queue head into
//    the result register that drives rsp_*.
//  - Throughput: one result item per cycle while rsp_stall is low; a request
//    gives 1 to 4 results, and the byte-wide result register walks the
//    queue head one byte at a time.
//  - The front classifies while the back drains; a 4-entry queue decouples
//    them, and req_stall rises only when that queue is full.
//  - Reset (synchronous) empties the queue, drops any pending lead, clears
//    the sticky error, turns pass-through off and sets little_endian=1.
//  - When rsp_stall is high on a valid result the result register holds,
//    the back stops, and the queue fills until req_stall asserts.
module utf16_to_utf8_transcoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [u16u8_pkg::UnitW-1:0]     req_code_unit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [u16u8_pkg::ByteW-1:0]     rsp_out_byte,
   output logic                            rsp_has_byte,
   output logic                            rsp_last,
   output logic                            rsp_pair_error,
   output logic                            rsp_status_error,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [u16u8_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [u16u8_pkg::CsrDataW-1:0]  csr_data
);

   // queue hookup between the two halves
   logic                 q_full, q_empty, q_push, q_pop;
   u16u8_pkg::entry_type q_in, q_head;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_in)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   u16u8_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_last         (rsp_last),
      .rsp_pair_error   (rsp_pair_error),
      .rsp_status_error (rsp_status_error)
   );

endmodule

// ===== rtl/core/u16u8_checker.sv =====
// Port-level checks for the transcoder, bound to the top level.
// Depends on u16u8_pkg and utf16_to_utf8_transcoder.
module u16u8_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [u16u8_pkg::ByteW-1:0]     rsp_out_byte,
   input logic                            rsp_has_byte,
   input logic                            rsp_last,
   input logic                            rsp_pair_error,
   input logic                            rsp_status_error
);

   // nothing left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a pairing fault is a lone marker that already shows the sticky bit
   a_pair_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_error) |-> (!rsp_has_byte && rsp_last && rsp_status_error))
      else $error("pair error result malformed");

   // no-byte markers carry a zero byte and close their request
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_out_byte == '0 && rsp_last))
      else $error("no-byte result malformed");

   // sticky error never drops between consecutive results
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_status_error) |=> (!rsp_valid || rsp_status_error))
      else $error("sticky error cleared");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);
